### rtl/core/tsrc_pkg.sv
// texture slot residency cache: shared sizes, entry layout and control structs
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package tsrc_pkg;

    localparam int NUM_IDS   = 256;
    localparam int NUM_SLOTS = 64;

    localparam int ID_W    = $clog2(NUM_IDS);
    localparam int SLOT_W  = $clog2(NUM_SLOTS);
    localparam int CNT_W   = $clog2(NUM_SLOTS + 1);
    localparam int TID_W   = 8;
    localparam int IDLE_W  = 9;
    localparam int LIMIT_W = 8;

    localparam int IN_BITS  = TID_W + 1;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = SLOT_W + 5;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [IDLE_W-1:0]  IDLE_MAX    = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd2;

    // one id's link record
    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
        logic [IDLE_W-1:0] idle;
    } entry_t;

    typedef struct packed {
        logic              rd_en;
        logic [ID_W-1:0]   rd_addr;
        logic              wr_en;
        logic [ID_W-1:0]   wr_addr;
        entry_t            wr_data;
    } ram_req_t;

    typedef struct packed {
        logic              claim;
        logic              create;
        logic [SLOT_W-1:0] claim_slot;
        logic              release_en;
        logic [SLOT_W-1:0] release_slot;
    } pool_cmd_t;

    typedef struct packed {
        logic              free_found;
        logic [SLOT_W-1:0] free_slot;
        logic              can_create;
        logic [SLOT_W-1:0] new_slot;
    } pool_stat_t;

    // result beat, slot in the lowest bits
    typedef struct packed {
        logic              no_slot;
        logic              null_result;
        logic              slot_created;
        logic              load_needed;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } result_t;

endpackage

`default_nettype wire

### rtl/core/texture_slot_residency_cache_top.sv
// texture slot residency cache, top level
// get: result via lookup and push states (null id: push state only), next item taken from the
// cycle it shows; frame tick: sweeps all NUM_IDS link entries through the memory, one read and
// one write of the link memory per cycle, then pushes its result
// reset: control and slot flags clear at once, then a pass clearing all NUM_IDS entries of the
// link memory during which no item is accepted; configuration writes are taken throughout
`timescale 1ns / 1ps
`default_nettype none

module texture_slot_residency_cache_top
    import tsrc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_wdata,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [IN_W-1:0]    s_tdata,   // texture_id, id_is_null
    input  wire logic               s_tuser,   // mode
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [OUT_W-1:0]        m_tdata    // slot, hit, load_needed, slot_created,
                                               // null_result, no_slot
);

    ram_req_t   ram_req;
    entry_t     ram_rd_data;
    pool_cmd_t  pool_cmd;
    pool_stat_t pool_stat;
    result_t    out_res;

    tsrc_entry_ram u_entry_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    tsrc_slot_pool u_slot_pool (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (pool_cmd),
        .stat  (pool_stat)
    );

    tsrc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser),
        .in_id       (s_tdata[TID_W-1:0]),
        .in_null     (s_tdata[TID_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_res     (out_res),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .pool_cmd    (pool_cmd),
        .pool_stat   (pool_stat)
    );

    assign m_tdata = OUT_W'(out_res);

`ifndef NO_ASSERTIONS
    // a slot is never claimed and freed in the same cycle
    a_claim_release_excl : assert property (@(posedge clk) disable iff (!rst_n)
        !(pool_cmd.claim && pool_cmd.release_en))
        else $error("slot claim and release in the same cycle");

    // a new slot is only created while the pool has room
    a_create_room : assert property (@(posedge clk) disable iff (!rst_n)
        (pool_cmd.claim && pool_cmd.create) |-> pool_stat.can_create)
        else $error("slot created with a full pool");

    // only one item in flight
    a_one_item : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("new item accepted while one is in progress");

    // a refused get carries no hit or load request
    a_no_slot_clean : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_res.no_slot) |-> (!out_res.hit && !out_res.load_needed))
        else $error("no_slot result with hit or load set");
`endif

endmodule

`default_nettype wire

### rtl/core/tsrc_entry_ram.sv
// texture slot residency cache: per-id link memory, one read and one write port
// depends on tsrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsrc_entry_ram
    import tsrc_pkg::*;
(
    input  wire logic     clk,
    input  wire ram_req_t req,
    output entry_t        rd_data
);

    entry_t mem [NUM_IDS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/core/tsrc_slot_pool.sv
// texture slot residency cache: slot allocation and activity flags, free-slot search
// depends on tsrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsrc_slot_pool
    import tsrc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire pool_cmd_t cmd,
    output pool_stat_t     stat
);

    logic [NUM_SLOTS-1:0] active_reg, active_next;
    logic [NUM_SLOTS-1:0] alloc_reg, alloc_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [NUM_SLOTS-1:0] free_vec;
    logic [SLOT_W-1:0]    free_idx;

    assign free_vec = alloc_reg & ~active_reg;

    // lowest allocated slot that is not in use
    always_comb
    begin
        free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        stat.free_found = |free_vec;
        stat.free_slot  = free_idx;
        stat.can_create = (count_reg < CNT_W'(NUM_SLOTS));
        stat.new_slot   = count_reg[SLOT_W-1:0];
    end

    always_comb
    begin
        active_next = active_reg;
        alloc_next  = alloc_reg;
        count_next  = count_reg;
        if (cmd.release_en)
        begin
            active_next[cmd.release_slot] = 1'b0;
        end
        if (cmd.claim)
        begin
            active_next[cmd.claim_slot] = 1'b1;
            if (cmd.create)
            begin
                alloc_next[cmd.claim_slot] = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            alloc_reg  <= '0;
            count_reg  <= '0;
        end
        else
        begin
            active_reg <= active_next;
            alloc_reg  <= alloc_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tsrc_ctrl.sv
// texture slot residency cache: sequencer for gets, frame-tick sweep and memory clear
// holds the limit register and the output register; depends on tsrc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tsrc_ctrl
    import tsrc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [LIMIT_W-1:0] cfg_wdata,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               in_mode,
    input  wire logic [TID_W-1:0]   in_id,
    input  wire logic               in_null,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output result_t                 out_res,
    output ram_req_t                ram_req,
    input  wire entry_t             ram_rd_data,
    output pool_cmd_t               pool_cmd,
    input  wire pool_stat_t         pool_stat
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_TICK,
        ST_PUSH
    } state_t;

    state_t               state_reg, state_next;
    logic [ID_W:0]        sweep_reg, sweep_next;
    logic                 wb_valid_reg, wb_valid_next;
    logic [ID_W-1:0]      wb_idx_reg, wb_idx_next;
    logic [ID_W-1:0]      id_reg, id_next;
    result_t              res_reg, res_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg, out_next;
    logic [LIMIT_W-1:0]   limit_reg, limit_next;
    logic [IDLE_W-1:0]    idle_inc;
    logic                 id_in_range;

    assign id_in_range = ({24'd0, in_id} < 32'(NUM_IDS));
    assign idle_inc    = (ram_rd_data.idle < IDLE_MAX) ? ram_rd_data.idle + 1'b1
                                                       : ram_rd_data.idle;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        wb_valid_next  = 1'b0;
        wb_idx_next    = wb_idx_reg;
        id_next        = id_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        limit_next     = cfg_we ? cfg_wdata : limit_reg;
        ram_req        = '0;
        pool_cmd       = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = sweep_reg[ID_W-1:0];
                ram_req.wr_data = '0;
                if (sweep_reg[ID_W-1:0] == ID_W'(NUM_IDS - 1))
                begin
                    sweep_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_next = '0;
                    if (in_mode)
                    begin
                        sweep_next = '0;
                        state_next = ST_TICK;
                    end
                    else if (in_null)
                    begin
                        res_next.null_result = 1'b1;
                        state_next = ST_PUSH;
                    end
                    else if (!id_in_range)
                    begin
                        res_next.no_slot = 1'b1;
                        state_next = ST_PUSH;
                    end
                    else
                    begin
                        ram_req.rd_en   = 1'b1;
                        ram_req.rd_addr = ID_W'(in_id);
                        id_next         = ID_W'(in_id);
                        state_next      = ST_LOOKUP;
                    end
                end
            end

            ST_LOOKUP:
            begin
                state_next      = ST_PUSH;
                ram_req.wr_addr = id_reg;
                ram_req.wr_data.valid = 1'b1;
                ram_req.wr_data.idle  = '0;
                if (ram_rd_data.valid)
                begin
                    ram_req.wr_en        = 1'b1;
                    ram_req.wr_data.slot = ram_rd_data.slot;
                    res_next.slot        = ram_rd_data.slot;
                    res_next.hit         = 1'b1;
                end
                else if (pool_stat.free_found)
                begin
                    ram_req.wr_en        = 1'b1;
                    ram_req.wr_data.slot = pool_stat.free_slot;
                    pool_cmd.claim       = 1'b1;
                    pool_cmd.claim_slot  = pool_stat.free_slot;
                    res_next.slot        = pool_stat.free_slot;
                    res_next.load_needed = 1'b1;
                end
                else if (pool_stat.can_create)
                begin
                    ram_req.wr_en         = 1'b1;
                    ram_req.wr_data.slot  = pool_stat.new_slot;
                    pool_cmd.claim        = 1'b1;
                    pool_cmd.create       = 1'b1;
                    pool_cmd.claim_slot   = pool_stat.new_slot;
                    res_next.slot         = pool_stat.new_slot;
                    res_next.load_needed  = 1'b1;
                    res_next.slot_created = 1'b1;
                end
                else
                begin
                    res_next.no_slot = 1'b1;
                end
            end

            ST_TICK:
            begin
                // read id n while writing back id n-1
                if (sweep_reg < (ID_W + 1)'(NUM_IDS))
                begin
                    ram_req.rd_en   = 1'b1;
                    ram_req.rd_addr = sweep_reg[ID_W-1:0];
                    wb_valid_next   = 1'b1;
                    wb_idx_next     = sweep_reg[ID_W-1:0];
                    sweep_next      = sweep_reg + 1'b1;
                end
                if (wb_valid_reg && ram_rd_data.valid)
                begin
                    ram_req.wr_en        = 1'b1;
                    ram_req.wr_addr      = wb_idx_reg;
                    ram_req.wr_data.slot = ram_rd_data.slot;
                    ram_req.wr_data.idle = idle_inc;
                    if (idle_inc > {1'b0, limit_reg})
                    begin
                        ram_req.wr_data.valid = 1'b0;
                        pool_cmd.release_en   = 1'b1;
                        pool_cmd.release_slot = ram_rd_data.slot;
                    end
                    else
                    begin
                        ram_req.wr_data.valid = 1'b1;
                    end
                end
                if (sweep_reg == (ID_W + 1)'(NUM_IDS) && !wb_valid_reg)
                begin
                    sweep_next = '0;
                    state_next = ST_PUSH;
                end
            end

            ST_PUSH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            wb_valid_reg  <= 1'b0;
            wb_idx_reg    <= '0;
            id_reg        <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            limit_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            wb_valid_reg  <= wb_valid_next;
            wb_idx_reg    <= wb_idx_next;
            id_reg        <= id_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
            limit_reg     <= limit_next;
        end
    end

endmodule

`default_nettype wire
